[hdl/aisd_pkg.sv]
// Shared types and constants for the packed array store.
// No dependencies; imported by aisd_ctrl and the top level.
package aisd_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int PW    = 6;
  localparam int BW    = 5;
  localparam int LW    = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_LSEARCH = 2'd2,
    OP_BSEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_LSR,
    S_BRD,
    S_BCMP,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t               status;
    logic [LW-1:0]         location;
    logic signed [DW-1:0]  removed_value;
    logic [CW-1:0]         count_after;
  } res_t;

endpackage

[hdl/aisd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module aisd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/aisd_ctrl.sv]
// Sequencer for insert, delete, linear and binary search over the element RAM.
// Depends on aisd_pkg; drives the ports of one aisd_ram instance.
module aisd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  aisd_pkg::op_t               in_operation,
  input  logic [aisd_pkg::PW-1:0]     in_position,
  input  logic [aisd_pkg::DW-1:0]     in_value,
  input  logic [aisd_pkg::BW-1:0]     in_low_bound,
  input  logic [aisd_pkg::BW-1:0]     in_high_bound,
  output logic                        res_valid,
  input  logic                        res_take,
  output aisd_pkg::res_t              res,
  output logic                        ram_wr_en,
  output logic [aisd_pkg::AW-1:0]     ram_wr_addr,
  output logic [aisd_pkg::DW-1:0]     ram_wr_data,
  output logic                        ram_rd_en,
  output logic [aisd_pkg::AW-1:0]     ram_rd_addr,
  input  logic [aisd_pkg::DW-1:0]     ram_rd_data
);
  import aisd_pkg::*;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [DW-1:0]       val_r, val_nxt;
  logic                wpend_r, wpend_nxt;
  logic [AW-1:0]       waddr_r, waddr_nxt;
  logic                cap_r, cap_nxt;
  logic                cmp_r, cmp_nxt;
  logic [AW-1:0]       caddr_r, caddr_nxt;
  logic signed [CW:0]  beg_r, beg_nxt;
  logic signed [CW:0]  end_r, end_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;
  status_t             status_r, status_nxt;
  logic [LW-1:0]       loc_r, loc_nxt;
  logic [DW-1:0]       removed_r, removed_nxt;

  logic                hit;
  logic                key_lt;
  logic                bs_go;
  logic [CW:0]         bs_sum;
  logic [AW-1:0]       bs_mid;
  logic                full;
  logic                ins_bad;
  logic                del_bad;
  logic                bs_bad;

  assign hit     = (ram_rd_data == val_r);
  assign key_lt  = $signed(val_r) < $signed(ram_rd_data);
  assign bs_go   = (beg_r <= end_r);
  assign bs_sum  = beg_r + end_r;
  assign bs_mid  = bs_sum[AW:1];
  assign full    = (cnt_r >= CW'(DEPTH));
  assign ins_bad = (in_position > cnt_r);
  assign del_bad = (in_position >= cnt_r);
  assign bs_bad  = ({1'b0, in_low_bound} >= cnt_r) || ({1'b0, in_high_bound} >= cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_operation)
            OP_INSERT:  state_nxt = (full || ins_bad) ? S_DONE : S_INS;
            OP_DELETE:  state_nxt = del_bad ? S_DONE : S_DEL;
            OP_LSEARCH: state_nxt = S_LSR;
            OP_BSEARCH: state_nxt = bs_bad ? S_DONE : S_BRD;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_INS:  if ((idx_r == CW'(pos_r)) && !wpend_r) state_nxt = S_DONE;
      S_DEL:  if ((idx_r == cnt_r) && !wpend_r && !cap_r) state_nxt = S_DONE;
      S_LSR:  if ((cmp_r && hit) || ((idx_r == cnt_r) && !cmp_r)) state_nxt = S_DONE;
      S_BRD:  state_nxt = bs_go ? S_BCMP : S_DONE;
      S_BCMP: if (hit) state_nxt = S_DONE; else state_nxt = S_BRD;
      S_DONE: if (res_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    wpend_nxt   = 1'b0;
    waddr_nxt   = waddr_r;
    cap_nxt     = 1'b0;
    cmp_nxt     = 1'b0;
    caddr_nxt   = caddr_r;
    beg_nxt     = beg_r;
    end_nxt     = end_r;
    mid_nxt     = mid_r;
    status_nxt  = status_r;
    loc_nxt     = loc_r;
    removed_nxt = removed_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt     = in_position;
          val_nxt     = in_value;
          loc_nxt     = '0;
          removed_nxt = '0;
          beg_nxt     = $signed({2'b00, in_low_bound});
          end_nxt     = $signed({2'b00, in_high_bound});
          case (in_operation)
            OP_INSERT: begin
              idx_nxt    = cnt_r;
              status_nxt = full ? ST_FULL : (ins_bad ? ST_BAD : ST_OK);
            end
            OP_DELETE: begin
              idx_nxt    = in_position;
              status_nxt = del_bad ? ST_BAD : ST_OK;
            end
            OP_LSEARCH: begin
              idx_nxt    = '0;
              status_nxt = ST_MISS;
            end
            default: begin
              status_nxt = bs_bad ? ST_BAD : ST_MISS;
            end
          endcase
        end
      end
      S_INS: begin
        // move word idx-1 up to idx; the write lands in the cycle after the read
        if (idx_r > CW'(pos_r)) begin
          idx_nxt   = idx_r - 1'b1;
          wpend_nxt = 1'b1;
          waddr_nxt = idx_r[AW-1:0];
        end else if (!wpend_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DEL: begin
        if (cap_r) begin
          removed_nxt = ram_rd_data;
        end
        if (idx_r < cnt_r) begin
          idx_nxt   = idx_r + 1'b1;
          wpend_nxt = (idx_r != CW'(pos_r));
          cap_nxt   = (idx_r == CW'(pos_r));
          waddr_nxt = idx_r[AW-1:0] - 1'b1;
        end else if (!wpend_r && !cap_r) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_LSR: begin
        if (cmp_r && hit) begin
          loc_nxt    = caddr_r;
          status_nxt = ST_OK;
        end else if (idx_r < cnt_r) begin
          idx_nxt   = idx_r + 1'b1;
          cmp_nxt   = 1'b1;
          caddr_nxt = idx_r[AW-1:0];
        end
      end
      S_BRD: begin
        if (bs_go) begin
          mid_nxt = bs_mid;
        end
      end
      S_BCMP: begin
        if (hit) begin
          loc_nxt    = mid_r;
          status_nxt = ST_OK;
        end else if (key_lt) begin
          end_nxt = $signed({2'b00, mid_r}) - 2'sd1;
        end else begin
          beg_nxt = $signed({2'b00, mid_r}) + 2'sd1;
        end
      end
      default: begin
      end
    endcase
  end

  // outputs and RAM ports
  always_comb begin
    in_ready    = (state_r == S_IDLE);
    res_valid   = (state_r == S_DONE);
    ram_wr_en   = 1'b0;
    ram_wr_addr = waddr_r;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_r[AW-1:0];
    unique case (state_r)
      S_INS: begin
        ram_rd_en   = (idx_r > CW'(pos_r));
        ram_rd_addr = idx_r[AW-1:0] - 1'b1;
        if (wpend_r) begin
          ram_wr_en = 1'b1;
        end else if (idx_r == CW'(pos_r)) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pos_r[AW-1:0];
          ram_wr_data = val_r;
        end
      end
      S_DEL: begin
        ram_rd_en = (idx_r < cnt_r);
        ram_wr_en = wpend_r;
      end
      S_LSR: begin
        ram_rd_en = (idx_r < cnt_r) && !(cmp_r && hit);
      end
      S_BRD: begin
        ram_rd_en   = bs_go;
        ram_rd_addr = bs_mid;
      end
      default: begin
      end
    endcase
  end

  assign res.status        = status_r;
  assign res.location      = loc_r;
  assign res.removed_value = $signed(removed_r);
  assign res.count_after   = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      wpend_r <= 1'b0;
      cap_r   <= 1'b0;
      cmp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wpend_r <= wpend_nxt;
      cap_r   <= cap_nxt;
      cmp_r   <= cmp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    waddr_r   <= waddr_nxt;
    caddr_r   <= caddr_nxt;
    beg_r     <= beg_nxt;
    end_r     <= end_nxt;
    mid_r     <= mid_nxt;
    status_r  <= status_nxt;
    loc_r     <= loc_nxt;
    removed_r <= removed_nxt;
  end

endmodule

[hdl/array_store_insert_delete_search.sv]
// Top level of the packed array store: element RAM, sequencer and result register.
// Depends on aisd_pkg, aisd_ram and aisd_ctrl.
//
//  channel  handshake             payload
//  in       in_valid / in_ready   operation, position, value, low_bound, high_bound
//  out      out_valid / out_ready status, location, removed_value, count_after
//
// One request at a time; the element RAM has one read and one write port.
// Insert and delete move one RAM word per cycle between the position and the end of
// the stored words; an insert that appends moves none. Linear search reads words in
// order until a hit or the end of the count; binary search halves the bound range
// with a read state and a compare state for each halving. Rejected requests go
// straight to the result. Reset clears the count; RAM contents stay.
// A finished result sits in the output register, so one further request is taken
// while out_ready is low; its result then waits until the register drains.
module array_store_insert_delete_search (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_operation,
  input  logic [aisd_pkg::PW-1:0]        in_position,
  input  logic signed [aisd_pkg::DW-1:0] in_value,
  input  logic [aisd_pkg::BW-1:0]        in_low_bound,
  input  logic [aisd_pkg::BW-1:0]        in_high_bound,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [aisd_pkg::LW-1:0]        out_location,
  output logic signed [aisd_pkg::DW-1:0] out_removed_value,
  output logic [aisd_pkg::CW-1:0]        out_count_after
);
  import aisd_pkg::*;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [DW-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [DW-1:0] ram_rd_data;
  logic          res_valid;
  logic          res_take;
  res_t          res;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r;

  aisd_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  aisd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (op_t'(in_operation)),
    .in_position   (in_position),
    .in_value      (in_value),
    .in_low_bound  (in_low_bound),
    .in_high_bound (in_high_bound),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data)
  );

  // load the result register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_location      = out_res_r.location;
  assign out_removed_value = out_res_r.removed_value;
  assign out_count_after   = out_res_r.count_after;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count_after <= CW'(DEPTH)))
    else $error("count_after exceeds store depth");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in progress");

  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_removed_value == '0))
    else $error("removed value set on a failed request");

  a_location_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_location != '0)) |-> (out_status == ST_OK))
    else $error("location set without a hit");

endmodule
